// ===== rtl/fsr_pkg.sv =====
// Shared constants, types and the binary32 round-and-pack function of the square root unit.
package fsr_pkg;

	// Significand width handed to the rounder and its signed exponent width.
	localparam int SIG_W = 51;
	localparam int EXP_W = 12;
	// Width of the shifted significand inside the rounder: one zero, SIG_W bits, 24 fraction bits.
	localparam int XW = SIG_W + 25;

	// Fixed operands of the algorithm.
	localparam logic [31:0] MAGIC_GUESS       = 32'h5f375a86;
	localparam logic [31:0] ONE_HALF_BITS     = 32'h3f000000;
	localparam logic [31:0] THREE_HALVES_BITS = 32'h3fc00000;
	localparam logic [31:0] CANON_NAN         = 32'h7fc00000;
	localparam logic [30:0] INF_MAG           = 31'h7f800000;

	// Pipeline depths of the units.
	localparam int MUL_LAT    = 2;
	localparam int SUB_LAT    = 2;
	localparam int NEWTON_LAT = 3 * MUL_LAT + SUB_LAT;
	localparam int TOTAL_LAT  = MUL_LAT + 2 * NEWTON_LAT + MUL_LAT;

	// Special-operand flags that travel from the first to the second stage of a unit.
	typedef struct packed {
		logic nan;
		logic inf;
		logic zero;
	} spec_t;

	// Rounds sign * m * 2^e to binary32 with round-to-nearest-even, denormals and overflow included.
	// The caller guarantees that m is not zero.
	function automatic logic [31:0] round_pack(input logic sign, input logic [SIG_W-1:0] m,
			input logic signed [EXP_W-1:0] e);
		logic [5:0]              k;
		logic signed [EXP_W-1:0] q;
		logic signed [EXP_W-1:0] t;
		logic [6:0]              ts;
		logic [XW-1:0]           x;
		logic [XW-1:0]           y;
		logic [XW-1:0]           mask;
		logic                    guard;
		logic                    sticky;
		logic [24:0]             r;
		logic [33:0]             total;
		logic [31:0]             res;
		// Position of the leading one.
		k = '0;
		for (int i = 0; i < SIG_W; i++) begin
			if (m[i]) k = 6'(i);
		end
		// Weight of the result's last place, never below that of the smallest denormal.
		q = $signed({6'b0, k}) + e - 12'sd23;
		if (q < -12'sd149) q = -12'sd149;
		// Right shift that brings that weight to bit zero.
		t = q - e + 12'sd24;
		if (t > 12'sd76) ts = 7'd76;
		else ts = t[6:0];
		x = {1'b0, m, 24'b0};
		y = x >> ts;
		guard = x[ts - 7'd1];
		mask = ~({XW{1'b1}} << (ts - 7'd1));
		sticky = |(x & mask);
		r = y[24:0] + 25'(guard & (sticky | y[0]));
		// The hidden bit adds one to the exponent field, so a carry out of rounding lands right.
		total = (34'($unsigned(q + 12'sd149)) << 23) + 34'(r);
		if (total >= 34'h07f800000) res = {sign, INF_MAG};
		else res = {sign, total[30:0]};
		return res;
	endfunction

endpackage

// ===== rtl/fsr_delay.sv =====
// Fixed-length register line that keeps a payload in step with the arithmetic pipeline.
module fsr_delay #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] delay_q [DEPTH];

	// First tap loads the input.
	always_ff @(posedge clk) begin
		delay_q[0] <= d;
	end

	// Remaining taps shift once per cycle.
	for (genvar i = 1; i < DEPTH; i++) begin : g_tap
		always_ff @(posedge clk) begin
			delay_q[i] <= delay_q[i-1];
		end
	end

	assign q = delay_q[DEPTH-1];

endmodule

// ===== rtl/fsr_fmul.sv =====
// Two-stage binary32 multiplier: significand product, then normalize and round.
module fsr_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] p
);

	logic [7:0]  ea, eb, eae, ebe;
	logic [23:0] ma, mb;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	fsr_pkg::spec_t spec_c;

	logic                            valid_s1, valid_s2;
	logic [47:0]                     prod_s1;
	logic signed [fsr_pkg::EXP_W-1:0] exp_s1;
	logic                            sign_s1;
	fsr_pkg::spec_t                  spec_s1;
	logic [31:0]                     res_s2;

	// Unpack both operands; a denormal uses exponent one without the hidden bit.
	always_comb begin
		ea = a[30:23];
		eb = b[30:23];
		ma = {ea != 8'd0, a[22:0]};
		mb = {eb != 8'd0, b[22:0]};
		eae = (ea == 8'd0) ? 8'd1 : ea;
		ebe = (eb == 8'd0) ? 8'd1 : eb;
		nan_a = (ea == 8'hff) && (a[22:0] != 23'd0);
		nan_b = (eb == 8'hff) && (b[22:0] != 23'd0);
		inf_a = (ea == 8'hff) && (a[22:0] == 23'd0);
		inf_b = (eb == 8'hff) && (b[22:0] == 23'd0);
		zero_a = (a[30:0] == 31'd0);
		zero_b = (b[30:0] == 31'd0);
		spec_c.nan = nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b);
		spec_c.inf = inf_a || inf_b;
		spec_c.zero = zero_a || zero_b;
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: significand product and exponent sum.
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		exp_s1 <= $signed({4'b0, eae}) + $signed({4'b0, ebe}) - 12'sd300;
		sign_s1 <= a[31] ^ b[31];
		spec_s1 <= spec_c;
	end

	// Stage two: special results first, otherwise round the exact product.
	always_ff @(posedge clk) begin
		priority if (spec_s1.nan) begin
			res_s2 <= fsr_pkg::CANON_NAN;
		end else if (spec_s1.inf) begin
			res_s2 <= {sign_s1, fsr_pkg::INF_MAG};
		end else if (spec_s1.zero) begin
			res_s2 <= {sign_s1, 31'd0};
		end else begin
			res_s2 <= fsr_pkg::round_pack(sign_s1, fsr_pkg::SIG_W'(prod_s1), exp_s1);
		end
	end

	assign out_valid = valid_s2;
	assign p = res_s2;

endmodule

// ===== rtl/fsr_fsub.sv =====
// Two-stage binary32 subtractor a - b: align and add, then normalize and round.
module fsr_fsub (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] d
);

	logic [7:0]  ea, eb, eae, ebe, e_hi, diff_e;
	logic [23:0] ma, mb, m_hi, m_lo;
	logic        sa, sbe, s_hi, s_lo;
	logic        nan_a, nan_b, inf_a, inf_b;
	logic [49:0] big, full_lo, aligned_lo, small_j;
	logic        st;
	logic [50:0] sum, mag;
	logic        sign_c;
	fsr_pkg::spec_t spec_c;

	logic                             valid_s1, valid_s2;
	logic [50:0]                      mag_s1;
	logic signed [fsr_pkg::EXP_W-1:0] exp_s1;
	logic                             sign_s1;
	fsr_pkg::spec_t                   spec_s1;
	logic [31:0]                      res_s2;

	// Unpack, order by exponent, align the smaller operand with a sticky bit and add.
	always_comb begin
		ea = a[30:23];
		eb = b[30:23];
		ma = {ea != 8'd0, a[22:0]};
		mb = {eb != 8'd0, b[22:0]};
		eae = (ea == 8'd0) ? 8'd1 : ea;
		ebe = (eb == 8'd0) ? 8'd1 : eb;
		sa = a[31];
		sbe = ~b[31];
		nan_a = (ea == 8'hff) && (a[22:0] != 23'd0);
		nan_b = (eb == 8'hff) && (b[22:0] != 23'd0);
		inf_a = (ea == 8'hff) && (a[22:0] == 23'd0);
		inf_b = (eb == 8'hff) && (b[22:0] == 23'd0);
		if (eae >= ebe) begin
			e_hi = eae;
			diff_e = eae - ebe;
			m_hi = ma;
			m_lo = mb;
			s_hi = sa;
			s_lo = sbe;
		end else begin
			e_hi = ebe;
			diff_e = ebe - eae;
			m_hi = mb;
			m_lo = ma;
			s_hi = sbe;
			s_lo = sa;
		end
		big = {m_hi, 26'b0};
		full_lo = {m_lo, 26'b0};
		if (diff_e > 8'd50) begin
			aligned_lo = '0;
			st = (m_lo != 24'd0);
		end else begin
			aligned_lo = full_lo >> diff_e;
			st = |(full_lo & ~({50{1'b1}} << diff_e));
		end
		small_j = aligned_lo | {49'b0, st};
		// Same effective signs add; otherwise subtract and take the magnitude.
		if (s_hi == s_lo) begin
			sum = {1'b0, big} + {1'b0, small_j};
			mag = sum;
			sign_c = s_hi;
		end else begin
			sum = {1'b0, big} - {1'b0, small_j};
			if (sum[50]) begin
				mag = -sum;
				sign_c = s_lo;
			end else begin
				mag = sum;
				sign_c = s_hi;
			end
		end
		// An exact zero is negative only when both effective operands are negative.
		if (mag == 51'd0) sign_c = s_hi & s_lo;
		spec_c.nan = nan_a || nan_b || (inf_a && inf_b && (sa != sbe));
		spec_c.inf = inf_a || inf_b;
		spec_c.zero = (mag == 51'd0);
		if (spec_c.inf) sign_c = inf_a ? sa : sbe;
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: exact magnitude, its exponent and sign.
	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		exp_s1 <= $signed({4'b0, e_hi}) - 12'sd176;
		sign_s1 <= sign_c;
		spec_s1 <= spec_c;
	end

	// Stage two: special results first, otherwise round.
	always_ff @(posedge clk) begin
		priority if (spec_s1.nan) begin
			res_s2 <= fsr_pkg::CANON_NAN;
		end else if (spec_s1.inf) begin
			res_s2 <= {sign_s1, fsr_pkg::INF_MAG};
		end else if (spec_s1.zero) begin
			res_s2 <= {sign_s1, 31'd0};
		end else begin
			res_s2 <= fsr_pkg::round_pack(sign_s1, mag_s1, exp_s1);
		end
	end

	assign out_valid = valid_s2;
	assign d = res_s2;

endmodule

// ===== rtl/fsr_newton.sv =====
// One pipelined Newton step of the reciprocal square root: y * (1.5 - (half * y) * y).
module fsr_newton (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] y,
	input  logic [31:0] half,
	output logic        out_valid,
	output logic [31:0] y_next
);

	logic        v_hy, v_hyy, v_corr;
	logic [31:0] hy, hyy, corr, y_d2, y_d6;

	// half * y.
	fsr_fmul u_mul_hy (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.a(half), .b(y), .out_valid(v_hy), .p(hy)
	);

	// y waits for the first product.
	fsr_delay #(.WIDTH(32), .DEPTH(fsr_pkg::MUL_LAT)) u_dly_y2 (
		.clk(clk), .d(y), .q(y_d2)
	);

	// (half * y) * y.
	fsr_fmul u_mul_hyy (
		.clk(clk), .arst_n(arst_n), .in_valid(v_hy),
		.a(hy), .b(y_d2), .out_valid(v_hyy), .p(hyy)
	);

	// 1.5 - hyy.
	fsr_fsub u_sub_corr (
		.clk(clk), .arst_n(arst_n), .in_valid(v_hyy),
		.a(fsr_pkg::THREE_HALVES_BITS), .b(hyy), .out_valid(v_corr), .d(corr)
	);

	// y waits for the correction factor.
	fsr_delay #(.WIDTH(32), .DEPTH(2 * fsr_pkg::MUL_LAT + fsr_pkg::SUB_LAT)) u_dly_y6 (
		.clk(clk), .d(y), .q(y_d6)
	);

	// y * corr.
	fsr_fmul u_mul_next (
		.clk(clk), .arst_n(arst_n), .in_valid(v_corr),
		.a(y_d6), .b(corr), .out_valid(out_valid), .p(y_next)
	);

endmodule

// ===== rtl/fast_float_square_root_unit.sv =====
// Top level of the pipelined fast square root: magic guess, two Newton steps, final product.
// done is high in the cycle just before the edge that takes the result.
// Throughput: one item per cycle; busy is always low, as the pipeline never stalls.
// The depth is set by ten binary32 operations in series, two register stages each.
// Reset clears only the valid bits of the pipeline; items in flight are dropped.
// The receiver cannot stall: each result stands on root_bits for exactly one cycle with done.
module fast_float_square_root_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] operand_bits,
	output logic        done,
	output logic [31:0] root_bits
);

	logic        accept;
	logic        v_half, v_y1, v_y2;
	logic [31:0] guess, guess_d2, half, half_d8, y1, y2, a_d18;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// First guess from the halved bit pattern.
	assign guess = fsr_pkg::MAGIC_GUESS - (operand_bits >> 1);

	// half = operand * 0.5.
	fsr_fmul u_mul_half (
		.clk(clk), .arst_n(arst_n), .in_valid(accept),
		.a(operand_bits), .b(fsr_pkg::ONE_HALF_BITS), .out_valid(v_half), .p(half)
	);

	// Guess waits for half.
	fsr_delay #(.WIDTH(32), .DEPTH(fsr_pkg::MUL_LAT)) u_dly_guess (
		.clk(clk), .d(guess), .q(guess_d2)
	);

	// First Newton step.
	fsr_newton u_step1 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_half),
		.y(guess_d2), .half(half), .out_valid(v_y1), .y_next(y1)
	);

	// half waits for the first step.
	fsr_delay #(.WIDTH(32), .DEPTH(fsr_pkg::NEWTON_LAT)) u_dly_half (
		.clk(clk), .d(half), .q(half_d8)
	);

	// Second Newton step.
	fsr_newton u_step2 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_y1),
		.y(y1), .half(half_d8), .out_valid(v_y2), .y_next(y2)
	);

	// The operand waits for the refined reciprocal root.
	fsr_delay #(.WIDTH(32), .DEPTH(fsr_pkg::MUL_LAT + 2 * fsr_pkg::NEWTON_LAT)) u_dly_a (
		.clk(clk), .d(operand_bits), .q(a_d18)
	);

	// root = operand * y; NaN results leave the multiplier already canonical.
	fsr_fmul u_mul_root (
		.clk(clk), .arst_n(arst_n), .in_valid(v_y2),
		.a(a_d18), .b(y2), .out_valid(done), .p(root_bits)
	);

	// A result appears only for an item accepted one pipeline depth earlier.
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, fsr_pkg::TOTAL_LAT))
		else $error("result without a matching accepted item");

	// The pipeline never refuses an item.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every NaN result is the canonical quiet NaN.
	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (root_bits[30:23] == 8'hff) && (root_bits[22:0] != 23'd0))
		|-> (root_bits == fsr_pkg::CANON_NAN))
		else $error("non-canonical NaN result");

endmodule
